FILE: design/gpam_pkg.sv
package gpam_pkg;

	localparam int DEF_MAX_FRAME_PIXELS    = 4194304;
	localparam int DEF_RATIO_FRACTION_BITS = 16;

	// quotient bits resolved per cycle by the chromaticity divider
	localparam int DIV_STEPS = 4;

	localparam int PIX_W     = 8;
	localparam int TOTAL_W   = 10;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int Q16_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_FLOOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOMINANCE_MARGIN = 1'd1;

	localparam logic [CFG_W-1:0] BRIGHTNESS_FLOOR_RST = 8'd50;
	localparam logic [CFG_W-1:0] DOMINANCE_MARGIN_RST = 8'd20;

	localparam logic MODE_GATHER   = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef struct packed {
		logic load_px;
		logic ch_step;
		logic acc;
		logic mean_ld;
		logic mean_step;
		logic mean_last;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic pass_end;
		logic need_mean;
	} sts_t;

endpackage

FILE: design/gpam_ctrl.sv
module gpam_ctrl #(
	parameter int RATIO_FRACTION_BITS = gpam_pkg::DEF_RATIO_FRACTION_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  gpam_pkg::sts_t sts,
	output gpam_pkg::cmd_t cmd
);
	import gpam_pkg::*;

	localparam int FB       = RATIO_FRACTION_BITS;
	localparam int CH_ITERS = (FB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int IT_W     = $clog2(FB);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_CHROMA  = 3'd1;
	localparam logic [2:0] ST_ACC     = 3'd2;
	localparam logic [2:0] ST_MEAN_LD = 3'd3;
	localparam logic [2:0] ST_MEAN    = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;

	logic [2:0]      state_q, state_d;
	logic [IT_W-1:0] iter_q, iter_d;
	logic            m_tvalid_q;
	logic            slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign s_tready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_px = 1'b1;
					iter_d      = IT_W'(CH_ITERS - 1);
					state_d     = ST_CHROMA;
				end
			end
			ST_CHROMA: begin
				cmd.ch_step = 1'b1;
				if (iter_q == '0) begin
					state_d = ST_ACC;
				end else begin
					iter_d = iter_q - 1'b1;
				end
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (sts.need_mean) begin
					state_d = ST_MEAN_LD;
				end else if (!sts.pass_end && slot_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_MEAN_LD: begin
				cmd.mean_ld = 1'b1;
				iter_d      = IT_W'(FB - 1);
				state_d     = ST_MEAN;
			end
			ST_MEAN: begin
				cmd.mean_step = 1'b1;
				if (iter_q == '0) begin
					cmd.mean_last = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					iter_d = iter_q - 1'b1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iter_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
			if (cmd.out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/gpam_datapath.sv
module gpam_datapath #(
	parameter int MAX_FRAME_PIXELS    = gpam_pkg::DEF_MAX_FRAME_PIXELS,
	parameter int RATIO_FRACTION_BITS = gpam_pkg::DEF_RATIO_FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gpam_pkg::cmd_t                    cmd,
	output gpam_pkg::sts_t                    sts,
	input  logic [gpam_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	input  logic                              s_tuser,
	input  logic                              cfg_we,
	input  logic [gpam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gpam_pkg::CFG_W-1:0]        cfg_data,
	output logic [gpam_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import gpam_pkg::*;

	localparam int FB       = RATIO_FRACTION_BITS;
	localparam int CH_ITERS = (FB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int CH_BITS  = CH_ITERS * DIV_STEPS;
	localparam int CNT_W    = $clog2(MAX_FRAME_PIXELS + 1);
	localparam int SUM_W    = FB + CNT_W;
	localparam int NUM_W    = SUM_W + 5;
	localparam int DEN_W    = CNT_W + 5;
	localparam logic [FB-1:0]    RATIO_MAX = {FB{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_PIXELS);

	logic [CFG_W-1:0] floor_q, margin_q;

	logic             mode_q, last_q;
	logic [PIX_W-1:0] red_q, green_q, blue_q;

	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] ch_rem_q, ch_rem_d;
	logic [CH_BITS-1:0] ch_quo_q;
	logic [DIV_STEPS-1:0] ch_bits;
	logic [FB-1:0]      chroma;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic [FB-1:0]    thr_q;

	logic [NUM_W-1:0] numer;
	logic [DEN_W-1:0] denom;
	logic [DEN_W-1:0] mn_den_q, mn_rem_q, mn_rem_d;
	logic [FB-1:0]    mn_dq_q, mn_dq_d;
	logic [DEN_W:0]   mn_trial;

	logic qual, acc_en, flag;
	logic [PIX_W:0] red_m, blue_m;
	logic [Q16_W-1:0] thr16;
	logic             flag_q;
	logic [Q16_W-1:0] thr_out_q;

	assign total = TOTAL_W'(red_q) + TOTAL_W'(green_q) + TOTAL_W'(blue_q);

	always_comb begin
		logic [TOTAL_W:0] trial;
		logic [TOTAL_W-1:0] rem;
		rem     = ch_rem_q;
		ch_bits = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem, 1'b0};
			if (trial >= {1'b0, total}) begin
				rem                       = TOTAL_W'(trial - {1'b0, total});
				ch_bits[DIV_STEPS-1-i]    = 1'b1;
			end else begin
				rem = trial[TOTAL_W-1:0];
			end
		end
		ch_rem_d = rem;
	end

	assign chroma = (TOTAL_W'(green_q) == total) ? RATIO_MAX : ch_quo_q[CH_BITS-1 -: FB];

	assign red_m  = {1'b0, red_q} + {1'b0, margin_q};
	assign blue_m = {1'b0, blue_q} + {1'b0, margin_q};
	assign qual   = ({1'b0, green_q} > red_m) && ({1'b0, green_q} > blue_m)
		&& (green_q > floor_q);
	assign acc_en = (mode_q == MODE_GATHER) && qual && (count_q < CNT_MAX);

	assign sts.pass_end  = (mode_q == MODE_GATHER) && last_q;
	assign sts.need_mean = sts.pass_end && ((count_q != '0) || acc_en);

	assign flag = (mode_q == MODE_GATHER) ? qual
		: ((total == '0) ? 1'b1 : !(chroma < thr_q));

	// mean * 23 / 25 as shift-add products
	assign numer = (NUM_W'(sum_q) << 4) + (NUM_W'(sum_q) << 2) + (NUM_W'(sum_q) << 1)
		+ NUM_W'(sum_q);
	assign denom = (DEN_W'(count_q) << 4) + (DEN_W'(count_q) << 3) + DEN_W'(count_q);

	assign mn_trial = {mn_rem_q, mn_dq_q[FB-1]};
	always_comb begin
		if (mn_trial >= {1'b0, mn_den_q}) begin
			mn_rem_d = DEN_W'(mn_trial - {1'b0, mn_den_q});
			mn_dq_d  = {mn_dq_q[FB-2:0], 1'b1};
		end else begin
			mn_rem_d = mn_trial[DEN_W-1:0];
			mn_dq_d  = {mn_dq_q[FB-2:0], 1'b0};
		end
	end

	generate
		if (FB >= Q16_W) begin : g_q16_trunc
			assign thr16 = thr_q[FB-1 -: Q16_W];
		end else begin : g_q16_ext
			assign thr16 = {thr_q, {(Q16_W-FB){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q  <= BRIGHTNESS_FLOOR_RST;
			margin_q <= DOMINANCE_MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS_FLOOR: floor_q  <= cfg_data;
				REG_DOMINANCE_MARGIN: margin_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			thr_q   <= '0;
		end else begin
			if (cmd.acc) begin
				if (acc_en) begin
					sum_q   <= sum_q + SUM_W'(chroma);
					count_q <= count_q + 1'b1;
				end
				if (sts.pass_end && !sts.need_mean) begin
					thr_q <= '0;
				end
			end
			if (cmd.mean_ld) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (cmd.mean_step && cmd.mean_last) begin
				thr_q <= mn_dq_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			mode_q   <= s_tuser;
			last_q   <= s_tlast;
			red_q    <= s_tdata[PIX_W-1:0];
			green_q  <= s_tdata[2*PIX_W-1:PIX_W];
			blue_q   <= s_tdata[3*PIX_W-1:2*PIX_W];
			ch_rem_q <= TOTAL_W'(s_tdata[2*PIX_W-1:PIX_W]);
		end
		if (cmd.ch_step) begin
			ch_rem_q <= ch_rem_d;
			ch_quo_q <= {ch_quo_q[CH_BITS-DIV_STEPS-1:0], ch_bits};
		end
		if (cmd.mean_ld) begin
			mn_den_q <= denom;
			mn_rem_q <= numer[NUM_W-1:FB];
			mn_dq_q  <= numer[FB-1:0];
		end
		if (cmd.mean_step) begin
			mn_rem_q <= mn_rem_d;
			mn_dq_q  <= mn_dq_d;
		end
		if (cmd.out_ld) begin
			flag_q    <= flag;
			thr_out_q <= thr16;
		end
	end

	assign m_tdata = {(OUT_DATA_W-Q16_W-1)'(0), thr_out_q, flag_q};

endmodule

FILE: design/green_pixel_adaptive_mask.sv
// Green pixel mask with an adaptive chromaticity threshold.
// Input stream s_*: one RGB pixel per transfer. s_tuser selects the pass
// (0 gather, 1 classify), s_tlast marks the last pixel of a gather pass.
// Output stream m_*: one result per pixel, the pixel flag and the current
// threshold as a Q0.16 fraction, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 brightness floor, 1 dominance margin); write only while idle.
// Each pixel is loaded, divided by the chromaticity divider, which resolves
// four quotient bits per cycle, and passes the accumulate step before its
// result is registered; a new pixel is taken only once the last one has been
// handed to the output register. The last gather pixel adds a bit-serial mean
// division for the threshold when any pixel was counted, and an extra emit
// state otherwise.
// Reset clears the sum, count and threshold, loads the registers with 50
// and 20 and empties the output register.
// When the receiver stalls, the result holds in the output register; the
// next pixel is still taken and computed, then waits until the output
// register frees.
module green_pixel_adaptive_mask #(
	parameter int MAX_FRAME_PIXELS    = gpam_pkg::DEF_MAX_FRAME_PIXELS,
	parameter int RATIO_FRACTION_BITS = gpam_pkg::DEF_RATIO_FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [gpam_pkg::IN_DATA_W-1:0]  s_tdata,   // red, green, blue
	input  logic                            s_tlast,   // last_pixel
	input  logic                            s_tuser,   // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gpam_pkg::OUT_DATA_W-1:0] m_tdata,   // pixel_flag, threshold_value, zero pad
	input  logic                            cfg_we,
	input  logic [gpam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpam_pkg::CFG_W-1:0]      cfg_data
);
	import gpam_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gpam_ctrl #(
		.RATIO_FRACTION_BITS(RATIO_FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpam_datapath #(
		.MAX_FRAME_PIXELS    (MAX_FRAME_PIXELS),
		.RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata)
	);

	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("pixel accepted while another is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("output register loaded while holding a result");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_px, cmd.ch_step, cmd.acc, cmd.mean_ld, cmd.mean_step}))
		else $error("datapath commands overlap");

	a_mean_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mean_ld |=> (cmd.mean_step && !s_tready))
		else $error("mean division did not start after load");

endmodule
